// File: rtl/core/sacache_pkg.sv
package sacache_pkg;

  localparam int SETS_DEF      = 64;
  localparam int WAYS_DEF      = 8;
  localparam int TAG_BITS_DEF  = 24;
  localparam int META_BITS_DEF = 32;

  localparam int MODE_W   = 1;
  localparam int TAG_W    = 24;
  localparam int SET_W    = 6;
  localparam int WAY_W    = 3;
  localparam int CNT_W    = 32;
  localparam int POLICY_W = 2;

  typedef enum logic [POLICY_W-1:0] {
    POL_LRU  = 2'd0,
    POL_FIFO = 2'd1,
    POL_LFU  = 2'd2,
    POL_NONE = 2'd3
  } policy_t;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TAG_W-1:0]  tag;
    logic [SET_W-1:0]  set_index;
  } in_word_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic             writeback;
    logic [CNT_W-1:0] reads_total;
    logic [CNT_W-1:0] writes_total;
    logic [CNT_W-1:0] read_misses;
    logic [CNT_W-1:0] write_misses;
    logic [CNT_W-1:0] writebacks_total;
  } out_word_t;

  // per-access event flags from the set logic to the counters
  typedef struct packed {
    logic fire;
    logic wr;
    logic miss;
    logic wb;
  } cnt_evt_t;

endpackage

// File: rtl/core/sacache_if.sv
interface sacache_in_if;
  logic                 valid;
  logic                 ready;
  sacache_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sacache_out_if;
  logic                  valid;
  logic                  ready;
  sacache_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/set_assoc_cache_tag_policy_top.sv
// channel | direction | payload
// in_     | sink      | mode, tag, set_index
// out_    | source    | hit, way, writeback, five running counters
// cfg_    | write     | policy (2 bits)
// an access first reads the set row from the tag and policy memories, then
// compares, chooses the way and writes the row back.
// one access is in flight at a time; the result sits in an output register
// and the next word is taken once it is free or being taken.
// synchronous active-low reset clears counters and policy, then a clearing
// pass over all SETS rows (64 by default) zeroes flags and meta; no word is
// taken until it ends.
module set_assoc_cache_tag_policy_top #(
  parameter int SETS      = sacache_pkg::SETS_DEF,
  parameter int WAYS      = sacache_pkg::WAYS_DEF,
  parameter int TAG_BITS  = sacache_pkg::TAG_BITS_DEF,
  parameter int META_BITS = sacache_pkg::META_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sacache_in_if.sink            in_ch,
  sacache_out_if.source         out_ch,
  input  logic                  cfg_we,
  input  logic [sacache_pkg::POLICY_W-1:0] cfg_wdata
);

  localparam int SA_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WI_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef enum logic [2:0] {
    ST_CLR  = 3'b001,
    ST_IDLE = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  sacache_pkg::policy_t policy_r;
  logic [SA_W-1:0]     set_r;
  logic [SA_W-1:0]     clr_r, clr_nxt;
  logic [TAG_BITS-1:0] tag_r;
  logic                wr_r;
  logic                out_valid_r;
  sacache_pkg::out_word_t out_r;

  logic [WAYS*TAG_BITS-1:0]  rd_tags;
  logic [WAYS*META_BITS-1:0] rd_meta, meta_new, mem_meta;
  logic [WAYS-1:0] rd_valid, rd_dirty;
  logic hit, wb, upd;
  logic [WI_W-1:0] way;
  logic [WAYS-1:0] valid_new, dirty_new, tag_mask;
  logic [WAYS-1:0] mem_tag_mask, mem_valid, mem_dirty;
  logic [sacache_pkg::CNT_W-1:0] c_rd, c_wr, c_rm, c_wm, c_wb;
  sacache_pkg::cnt_evt_t evt;
  logic accept, fire, clearing, mem_we;
  logic [SA_W-1:0] in_set, mem_wa;
  logic [TAG_BITS-1:0] in_tag;

  // set number wrapped modulo SETS through a constant table
  always_comb begin
    in_set = '0;
    for (int v = 0; v < (1 << sacache_pkg::SET_W); v++) begin
      if (in_ch.data.set_index == sacache_pkg::SET_W'(v)) in_set = SA_W'(v % SETS);
    end
  end

  assign in_tag = TAG_BITS'({24'd0, in_ch.data.tag});
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept = in_ch.valid && in_ch.ready;
  assign fire = (state_r == ST_UPD);
  assign clearing = (state_r == ST_CLR);

  // policy register
  always_ff @(posedge clk) begin
    if (!rst_n) policy_r <= sacache_pkg::POL_LRU;
    else if (cfg_we) policy_r <= sacache_pkg::policy_t'(cfg_wdata);
  end

  // sequencer
  always_comb begin
    case (state_r)
      ST_CLR:  state_nxt = (clr_r == SA_W'(SETS - 1)) ? ST_IDLE : ST_CLR;
      ST_IDLE: state_nxt = accept ? ST_UPD : ST_IDLE;
      ST_UPD:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLR;
    else        state_r <= state_nxt;
  end

  // clearing pass row counter
  assign clr_nxt = clr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (clearing) clr_r <= clr_nxt;
  end

  // latch the access word
  always_ff @(posedge clk) begin
    if (accept) begin
      set_r <= in_set;
      tag_r <= in_tag;
      wr_r  <= in_ch.data.mode == sacache_pkg::MODE_WRITE;
    end
  end

  // row write: zeroes during the clearing pass, else the updated set
  assign mem_we       = clearing || (fire && upd);
  assign mem_wa       = clearing ? clr_r : set_r;
  assign mem_tag_mask = clearing ? '0 : tag_mask;
  assign mem_valid    = clearing ? '0 : valid_new;
  assign mem_dirty    = clearing ? '0 : dirty_new;
  assign mem_meta     = clearing ? '0 : meta_new;

  sacache_set_mem #(.SETS(SETS), .WAYS(WAYS), .TAG_BITS(TAG_BITS),
                    .META_BITS(META_BITS)) u_mem (
    .clk(clk), .rd_en(accept), .rd_addr(in_set), .rd_tags(rd_tags),
    .rd_valid(rd_valid), .rd_dirty(rd_dirty), .rd_meta(rd_meta),
    .wr_en(mem_we), .wr_addr(mem_wa), .wr_tag_mask(mem_tag_mask),
    .wr_tags({WAYS{tag_r}}), .wr_valid(mem_valid), .wr_dirty(mem_dirty),
    .wr_meta(mem_meta)
  );

  sacache_set_update #(.WAYS(WAYS), .TAG_BITS(TAG_BITS), .META_BITS(META_BITS)) u_upd (
    .policy(policy_r), .wr(wr_r), .tag(tag_r), .valid(rd_valid),
    .dirty(rd_dirty), .tags(rd_tags), .meta(rd_meta), .hit(hit), .way(way),
    .wb(wb), .upd(upd), .valid_new(valid_new), .dirty_new(dirty_new),
    .tag_mask(tag_mask), .meta_new(meta_new)
  );

  assign evt = '{fire: fire, wr: wr_r, miss: !hit, wb: wb};

  sacache_counters u_cnt (
    .clk(clk), .rst_n(rst_n), .evt(evt), .reads_r(c_rd), .writes_r(c_wr),
    .rmiss_r(c_rm), .wmiss_r(c_wm), .wb_r(c_wb)
  );

  // output register, counters include this access
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (fire) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r.hit              <= hit;
      out_r.way              <= sacache_pkg::WAY_W'({{sacache_pkg::WAY_W{1'b0}}, way});
      out_r.writeback        <= wb;
      out_r.reads_total      <= c_rd + {31'd0, !wr_r};
      out_r.writes_total     <= c_wr + {31'd0, wr_r};
      out_r.read_misses      <= c_rm + {31'd0, !wr_r && !hit};
      out_r.write_misses     <= c_wm + {31'd0, wr_r && !hit};
      out_r.writebacks_total <= c_wb + {31'd0, wb};
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

endmodule

// File: rtl/core/sacache_counters.sv
module sacache_counters (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sacache_pkg::cnt_evt_t           evt,
  output logic [sacache_pkg::CNT_W-1:0]   reads_r,
  output logic [sacache_pkg::CNT_W-1:0]   writes_r,
  output logic [sacache_pkg::CNT_W-1:0]   rmiss_r,
  output logic [sacache_pkg::CNT_W-1:0]   wmiss_r,
  output logic [sacache_pkg::CNT_W-1:0]   wb_r
);

  // running access counters, wrap at 32 bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reads_r  <= '0;
      writes_r <= '0;
      rmiss_r  <= '0;
      wmiss_r  <= '0;
      wb_r     <= '0;
    end else if (evt.fire) begin
      if (evt.wr) writes_r <= writes_r + 1'b1;
      else        reads_r  <= reads_r + 1'b1;
      if (evt.miss && evt.wr)  wmiss_r <= wmiss_r + 1'b1;
      if (evt.miss && !evt.wr) rmiss_r <= rmiss_r + 1'b1;
      if (evt.wb) wb_r <= wb_r + 1'b1;
    end
  end

endmodule

// File: rtl/core/sacache_set_mem.sv
module sacache_set_mem #(
  parameter int SETS      = sacache_pkg::SETS_DEF,
  parameter int WAYS      = sacache_pkg::WAYS_DEF,
  parameter int TAG_BITS  = sacache_pkg::TAG_BITS_DEF,
  parameter int META_BITS = sacache_pkg::META_BITS_DEF,
  localparam int SA_W     = (SETS > 1) ? $clog2(SETS) : 1
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [SA_W-1:0]            rd_addr,
  output logic [WAYS*TAG_BITS-1:0]   rd_tags,
  output logic [WAYS-1:0]            rd_valid,
  output logic [WAYS-1:0]            rd_dirty,
  output logic [WAYS*META_BITS-1:0]  rd_meta,
  input  logic                       wr_en,
  input  logic [SA_W-1:0]            wr_addr,
  input  logic [WAYS-1:0]            wr_tag_mask,
  input  logic [WAYS*TAG_BITS-1:0]   wr_tags,
  input  logic [WAYS-1:0]            wr_valid,
  input  logic [WAYS-1:0]            wr_dirty,
  input  logic [WAYS*META_BITS-1:0]  wr_meta
);

  localparam int ROW_W = 2*WAYS + WAYS*META_BITS;

  logic [WAYS*TAG_BITS-1:0] tag_mem  [SETS];
  logic [ROW_W-1:0]         meta_mem [SETS];
  logic [ROW_W-1:0]         rd_row;

  // tag row, per-way write mask
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int w = 0; w < WAYS; w++) begin
        if (wr_tag_mask[w]) tag_mem[wr_addr][w*TAG_BITS +: TAG_BITS] <=
            wr_tags[w*TAG_BITS +: TAG_BITS];
      end
    end
    if (rd_en) rd_tags <= tag_mem[rd_addr];
  end

  // policy row: valid and dirty flags with the meta counts, whole row written back
  always_ff @(posedge clk) begin
    if (wr_en) meta_mem[wr_addr] <= {wr_valid, wr_dirty, wr_meta};
    if (rd_en) rd_row <= meta_mem[rd_addr];
  end

  assign rd_valid = rd_row[ROW_W-1 -: WAYS];
  assign rd_dirty = rd_row[WAYS*META_BITS +: WAYS];
  assign rd_meta  = rd_row[WAYS*META_BITS-1:0];

endmodule

// File: rtl/core/sacache_set_update.sv
module sacache_set_update #(
  parameter int WAYS      = sacache_pkg::WAYS_DEF,
  parameter int TAG_BITS  = sacache_pkg::TAG_BITS_DEF,
  parameter int META_BITS = sacache_pkg::META_BITS_DEF,
  localparam int WI_W     = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  sacache_pkg::policy_t       policy,
  input  logic                       wr,
  input  logic [TAG_BITS-1:0]        tag,
  input  logic [WAYS-1:0]            valid,
  input  logic [WAYS-1:0]            dirty,
  input  logic [WAYS*TAG_BITS-1:0]   tags,
  input  logic [WAYS*META_BITS-1:0]  meta,
  output logic                       hit,
  output logic [WI_W-1:0]            way,
  output logic                       wb,
  output logic                       upd,
  output logic [WAYS-1:0]            valid_new,
  output logic [WAYS-1:0]            dirty_new,
  output logic [WAYS-1:0]            tag_mask,
  output logic [WAYS*META_BITS-1:0]  meta_new
);

  logic [META_BITS-1:0] mx, mn, target, m;
  logic [WI_W-1:0]      hit_way, empty_way, vic_way;
  logic                 have_empty, found;

  always_comb begin
    hit = 1'b0; hit_way = '0;
    have_empty = 1'b0; empty_way = '0;
    mx = '0; mn = meta[META_BITS-1:0];
    // lookup, extremes and first empty way
    for (int i = 0; i < WAYS; i++) begin
      m = meta[i*META_BITS +: META_BITS];
      if (!hit && valid[i] && tags[i*TAG_BITS +: TAG_BITS] == tag) begin
        hit = 1'b1; hit_way = WI_W'(i);
      end
      if (m > mx) mx = m;
      if (m < mn) mn = m;
      if (!have_empty && !valid[i]) begin
        have_empty = 1'b1; empty_way = WI_W'(i);
      end
    end
    // victim by policy
    target = (policy == sacache_pkg::POL_FIFO) ? mx : mn;
    found = 1'b0; vic_way = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!found && meta[i*META_BITS +: META_BITS] == target) begin
        found = 1'b1; vic_way = WI_W'(i);
      end
    end
    upd = (policy != sacache_pkg::POL_NONE);
    if (hit) way = hit_way;
    else if (!upd) way = '0;
    else way = have_empty ? empty_way : vic_way;

    valid_new = valid; dirty_new = dirty; tag_mask = '0; meta_new = meta; wb = 1'b0;
    if (upd) begin
      if (hit) begin
        case (policy)
          sacache_pkg::POL_LRU: meta_new[way*META_BITS +: META_BITS] = mx + 1'b1;
          sacache_pkg::POL_FIFO: begin
            for (int i = 0; i < WAYS; i++)
              meta_new[i*META_BITS +: META_BITS] = meta[i*META_BITS +: META_BITS] + 1'b1;
          end
          default: meta_new[way*META_BITS +: META_BITS] =
              meta[way*META_BITS +: META_BITS] + 1'b1;
        endcase
        if (wr) dirty_new[way] = 1'b1;
      end else begin
        tag_mask[way] = 1'b1;
        valid_new[way] = 1'b1;
        case (policy)
          sacache_pkg::POL_LRU: meta_new[way*META_BITS +: META_BITS] = mx + 1'b1;
          sacache_pkg::POL_FIFO: begin
            for (int i = 0; i < WAYS; i++)
              meta_new[i*META_BITS +: META_BITS] = (WI_W'(i) == way) ? '0 :
                  meta[i*META_BITS +: META_BITS] + 1'b1;
          end
          default: meta_new[way*META_BITS +: META_BITS] = mn + 1'b1;
        endcase
        wb = dirty[way];
        dirty_new[way] = wr;
      end
    end
  end

endmodule
